[hw/rtl/nearest_grid_point_snap_core_defines.svh]
// Assertion macros shared by the checker of the grid point snap core.
// No dependencies; include by bare file name.
`ifndef NEAREST_GRID_POINT_SNAP_CORE_DEFINES_SVH
`define NEAREST_GRID_POINT_SNAP_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define NGPS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define NGPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ngps_pkg.sv]
// Package of the grid point snap core: widths, register codes, reset values,
// candidate type and the tie-aware candidate pick. No dependencies.
`default_nettype none

package ngps_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int SPACING_BITS   = 8;
  localparam int DIFF_BITS      = SPACING_BITS + 1;
  localparam int SQ_BITS        = 2 * DIFF_BITS;
  localparam int DIST_BITS      = SQ_BITS + 1;
  localparam int CFG_IDX_BITS   = 2;

  localparam int WIDTH_RESET   = 800;
  localparam int HEIGHT_RESET  = 600;
  localparam int SPACING_RESET = 10;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_WIDTH   = 2'd0,
    REG_HEIGHT  = 2'd1,
    REG_SPACING = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0] col_ok;
    logic [2:0] row_ok;
  } ngps_flags_t;

  typedef struct packed {
    logic                 ok;
    logic [DIST_BITS-1:0] sq_dist;
    logic [1:0]           col;
    logic [1:0]           row;
  } ngps_cand_t;

  // The first argument is earlier in scan order and wins ties.
  function automatic ngps_cand_t ngps_pick(ngps_cand_t a, ngps_cand_t b);
    ngps_cand_t r;
    if (b.ok && (!a.ok || (b.sq_dist < a.sq_dist))) begin
      r = b;
    end else begin
      r = a;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/ngps_point_if.sv]
// Query point channel of the grid point snap core.
// Depends on ngps_pkg.
`default_nettype none

interface ngps_point_if import ngps_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

`default_nettype wire

[hw/rtl/ngps_snap_if.sv]
// Snapped point result channel of the grid point snap core.
// Depends on ngps_pkg.
`default_nettype none

interface ngps_snap_if import ngps_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] snap_x;
  logic [COORD_BITS-1:0] snap_y;
  logic                  found;

  modport source (output valid, output snap_x, output snap_y, output found, input ready);
  modport sink   (input valid, input snap_x, input snap_y, input found, output ready);
endinterface

`default_nettype wire

[hw/rtl/ngps_div.sv]
// Pipelined restoring remainder unit: x mod spacing and y mod spacing,
// one bit of each coordinate per stage. Depends on ngps_pkg.
`default_nettype none

module ngps_div import ngps_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [COORD_BITS-1:0]   in_x,
  input  logic [COORD_BITS-1:0]   in_y,
  input  logic [SPACING_BITS-1:0] spacing,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [COORD_BITS-1:0]   out_x,
  output logic [COORD_BITS-1:0]   out_y,
  output logic [SPACING_BITS-1:0] out_rx,
  output logic [SPACING_BITS-1:0] out_ry
);

  logic                    v   [COORD_BITS+1];
  logic                    rdy [COORD_BITS+1];
  logic [COORD_BITS-1:0]   px  [COORD_BITS+1];
  logic [COORD_BITS-1:0]   py  [COORD_BITS+1];
  logic [SPACING_BITS-1:0] rx  [COORD_BITS+1];
  logic [SPACING_BITS-1:0] ry  [COORD_BITS+1];
  logic [SPACING_BITS:0]   s_ext;

  assign s_ext = {1'b0, spacing};

  assign v[0]   = in_valid;
  assign px[0]  = in_x;
  assign py[0]  = in_y;
  assign rx[0]  = '0;
  assign ry[0]  = '0;
  assign rdy[COORD_BITS] = out_ready;
  assign in_ready = rdy[0];

  for (genvar k = 0; k < COORD_BITS; k++) begin : g_stage
    logic [SPACING_BITS:0]   tx;
    logic [SPACING_BITS:0]   ty;
    logic [SPACING_BITS-1:0] rx_next;
    logic [SPACING_BITS-1:0] ry_next;

    assign rdy[k] = !v[k+1] || rdy[k+1];
    assign tx = {rx[k], px[k][COORD_BITS-1-k]};
    assign ty = {ry[k], py[k][COORD_BITS-1-k]};
    assign rx_next = (tx >= s_ext) ? SPACING_BITS'(tx - s_ext) : SPACING_BITS'(tx);
    assign ry_next = (ty >= s_ext) ? SPACING_BITS'(ty - s_ext) : SPACING_BITS'(ty);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (rdy[k]) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && v[k]) begin
        px[k+1] <= px[k];
        py[k+1] <= py[k];
        rx[k+1] <= rx_next;
        ry[k+1] <= ry_next;
      end
    end
  end

  assign out_valid = v[COORD_BITS];
  assign out_x     = px[COORD_BITS];
  assign out_y     = py[COORD_BITS];
  assign out_rx    = rx[COORD_BITS];
  assign out_ry    = ry[COORD_BITS];

endmodule

`default_nettype wire

[hw/rtl/ngps_cand.sv]
// Candidate stage: the three lattice columns and rows around the point,
// their range checks and the distance magnitudes. Depends on ngps_pkg.
`default_nettype none

module ngps_cand import ngps_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [COORD_BITS-1:0]   image_width,
  input  logic [COORD_BITS-1:0]   image_height,
  input  logic [SPACING_BITS-1:0] grid_spacing,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [COORD_BITS-1:0]   in_x,
  input  logic [COORD_BITS-1:0]   in_y,
  input  logic [SPACING_BITS-1:0] in_rx,
  input  logic [SPACING_BITS-1:0] in_ry,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [COORD_BITS-1:0]   gx [3],
  output logic [COORD_BITS-1:0]   gy [3],
  output logic [DIFF_BITS-1:0]    ax [3],
  output logic [DIFF_BITS-1:0]    ay [3],
  output ngps_flags_t             flags
);

  localparam int EW = COORD_BITS + 2;

  logic          v;
  logic [EW-1:0] s_ext;
  logic [EW-1:0] bx;
  logic [EW-1:0] by;
  logic          s_ok;
  ngps_flags_t   flags_next;

  // Lattice points base - s, base, base + s; a point g is inside when
  // g >= s and g + s <= limit.
  function automatic logic [2:0] axis_ok(logic [EW-1:0] base, logic [EW-1:0] s,
                                         logic [EW-1:0] limit);
    logic [2:0] ok;
    ok[0] = (base >= (s << 1)) && (base <= limit);
    ok[1] = (base >= s) && ((base + s) <= limit);
    ok[2] = (base + (s << 1)) <= limit;
    return ok;
  endfunction

  assign s_ext = EW'(grid_spacing);
  assign bx    = EW'(in_x) - EW'(in_rx);
  assign by    = EW'(in_y) - EW'(in_ry);
  assign s_ok  = grid_spacing != '0;
  assign flags_next.col_ok = s_ok ? axis_ok(bx, s_ext, EW'(image_width)) : 3'b000;
  assign flags_next.row_ok = s_ok ? axis_ok(by, s_ext, EW'(image_height)) : 3'b000;

  assign in_ready  = !v || out_ready;
  assign out_valid = v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      gx[0] <= COORD_BITS'(bx - s_ext);
      gx[1] <= COORD_BITS'(bx);
      gx[2] <= COORD_BITS'(bx + s_ext);
      gy[0] <= COORD_BITS'(by - s_ext);
      gy[1] <= COORD_BITS'(by);
      gy[2] <= COORD_BITS'(by + s_ext);
      ax[0] <= DIFF_BITS'(in_rx) + DIFF_BITS'(grid_spacing);
      ax[1] <= DIFF_BITS'(in_rx);
      ax[2] <= DIFF_BITS'(grid_spacing) - DIFF_BITS'(in_rx);
      ay[0] <= DIFF_BITS'(in_ry) + DIFF_BITS'(grid_spacing);
      ay[1] <= DIFF_BITS'(in_ry);
      ay[2] <= DIFF_BITS'(grid_spacing) - DIFF_BITS'(in_ry);
      flags <= flags_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ngps_select.sv]
// Selection pipeline: squares, nine squared distances and a registered
// compare tree that keeps the earliest candidate on ties. Depends on ngps_pkg.
`default_nettype none

module ngps_select import ngps_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] gx [3],
  input  logic [COORD_BITS-1:0] gy [3],
  input  logic [DIFF_BITS-1:0]  ax [3],
  input  logic [DIFF_BITS-1:0]  ay [3],
  input  ngps_flags_t           flags,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] snap_x,
  output logic [COORD_BITS-1:0] snap_y,
  output logic                  found
);

  logic v1, v2, v3, v4;
  logic r0, r1, r2, r3;

  logic [SQ_BITS-1:0]    sqx [3];
  logic [SQ_BITS-1:0]    sqy [3];
  ngps_flags_t           flags1;
  logic [COORD_BITS-1:0] gx1 [3];
  logic [COORD_BITS-1:0] gy1 [3];
  logic [COORD_BITS-1:0] gx2 [3];
  logic [COORD_BITS-1:0] gy2 [3];
  logic [COORD_BITS-1:0] gx3 [3];
  logic [COORD_BITS-1:0] gy3 [3];

  ngps_cand_t cc [9];
  ngps_cand_t c2_next [5];
  ngps_cand_t c2 [5];
  ngps_cand_t c3 [3];
  ngps_cand_t win;
  logic [COORD_BITS-1:0] sel_x;
  logic [COORD_BITS-1:0] sel_y;

  assign r3 = !v4 || out_ready;
  assign r2 = !v3 || r3;
  assign r1 = !v2 || r2;
  assign r0 = !v1 || r1;
  assign in_ready  = r0;
  assign out_valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (r0) begin
        v1 <= in_valid;
      end
      if (r1) begin
        v2 <= v1;
      end
      if (r2) begin
        v3 <= v2;
      end
      if (r3) begin
        v4 <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r0 && in_valid) begin
      for (int i = 0; i < 3; i++) begin
        sqx[i] <= SQ_BITS'(ax[i]) * SQ_BITS'(ax[i]);
        sqy[i] <= SQ_BITS'(ay[i]) * SQ_BITS'(ay[i]);
        gx1[i] <= gx[i];
        gy1[i] <= gy[i];
      end
      flags1 <= flags;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        cc[c*3+r].ok      = flags1.col_ok[c] && flags1.row_ok[r];
        cc[c*3+r].sq_dist = DIST_BITS'(sqx[c]) + DIST_BITS'(sqy[r]);
        cc[c*3+r].col     = 2'(c);
        cc[c*3+r].row     = 2'(r);
      end
    end
    for (int i = 0; i < 4; i++) begin
      c2_next[i] = ngps_pick(cc[2*i], cc[2*i+1]);
    end
    c2_next[4] = cc[8];
  end

  always_ff @(posedge clk) begin
    if (r1 && v1) begin
      c2  <= c2_next;
      gx2 <= gx1;
      gy2 <= gy1;
    end
  end

  always_ff @(posedge clk) begin
    if (r2 && v2) begin
      c3[0] <= ngps_pick(c2[0], c2[1]);
      c3[1] <= ngps_pick(c2[2], c2[3]);
      c3[2] <= c2[4];
      gx3   <= gx2;
      gy3   <= gy2;
    end
  end

  always_comb begin
    win = ngps_pick(ngps_pick(c3[0], c3[1]), c3[2]);
    case (win.col)
      2'd0:    sel_x = gx3[0];
      2'd1:    sel_x = gx3[1];
      2'd2:    sel_x = gx3[2];
      default: sel_x = '0;
    endcase
    case (win.row)
      2'd0:    sel_y = gy3[0];
      2'd1:    sel_y = gy3[1];
      2'd2:    sel_y = gy3[2];
      default: sel_y = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (r3 && v3) begin
      found  <= win.ok;
      snap_x <= win.ok ? sel_x : '0;
      snap_y <= win.ok ? sel_y : '0;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/nearest_grid_point_snap_core.sv]
// Top level of the grid point snap core: configuration registers and the
// remainder, candidate and selection pipelines. Depends on ngps_pkg and the
// point and snap interfaces.
//
//   channel  | role   | payload
//   ---------+--------+-------------------------------
//   point    | sink   | point_x, point_y
//   snap     | source | snap_x, snap_y, found
//   cfg      | write  | cfg_wen, cfg_index, cfg_wdata
//
// One transaction per cycle is accepted while the snap channel is not stalled;
// a point passes through the remainder unit, which resolves one coordinate
// bit per stage, then one candidate stage and four selection stages.
// Every stage holds its data while the next one is full and cannot move on, so a
// stall on the snap channel backs up stage by stage without loss or repetition.
// Reset clears the valid bits and loads the register reset values.
`default_nettype none

module nearest_grid_point_snap_core import ngps_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wen,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]   cfg_wdata,
  ngps_point_if.sink              point,
  ngps_snap_if.source             snap
);

  logic [COORD_BITS-1:0]   image_width;
  logic [COORD_BITS-1:0]   image_height;
  logic [SPACING_BITS-1:0] grid_spacing;

  logic                    div_valid;
  logic                    div_ready;
  logic [COORD_BITS-1:0]   div_x;
  logic [COORD_BITS-1:0]   div_y;
  logic [SPACING_BITS-1:0] div_rx;
  logic [SPACING_BITS-1:0] div_ry;

  logic                    cand_valid;
  logic                    cand_ready;
  logic [COORD_BITS-1:0]   cand_gx [3];
  logic [COORD_BITS-1:0]   cand_gy [3];
  logic [DIFF_BITS-1:0]    cand_ax [3];
  logic [DIFF_BITS-1:0]    cand_ay [3];
  ngps_flags_t             cand_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= COORD_BITS'(WIDTH_RESET);
      image_height <= COORD_BITS'(HEIGHT_RESET);
      grid_spacing <= SPACING_BITS'(SPACING_RESET);
    end else if (cfg_wen) begin
      case (cfg_reg_t'(cfg_index))
        REG_WIDTH:   image_width  <= cfg_wdata;
        REG_HEIGHT:  image_height <= cfg_wdata;
        REG_SPACING: grid_spacing <= cfg_wdata[SPACING_BITS-1:0];
        default: ;
      endcase
    end
  end

  ngps_div #(.COORD_BITS(COORD_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (point.valid),
    .in_ready  (point.ready),
    .in_x      (point.point_x),
    .in_y      (point.point_y),
    .spacing   (grid_spacing),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_x     (div_x),
    .out_y     (div_y),
    .out_rx    (div_rx),
    .out_ry    (div_ry)
  );

  ngps_cand #(.COORD_BITS(COORD_BITS)) u_cand (
    .clk          (clk),
    .rst          (rst),
    .image_width  (image_width),
    .image_height (image_height),
    .grid_spacing (grid_spacing),
    .in_valid     (div_valid),
    .in_ready     (div_ready),
    .in_x         (div_x),
    .in_y         (div_y),
    .in_rx        (div_rx),
    .in_ry        (div_ry),
    .out_valid    (cand_valid),
    .out_ready    (cand_ready),
    .gx           (cand_gx),
    .gy           (cand_gy),
    .ax           (cand_ax),
    .ay           (cand_ay),
    .flags        (cand_flags)
  );

  ngps_select #(.COORD_BITS(COORD_BITS)) u_select (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cand_valid),
    .in_ready  (cand_ready),
    .gx        (cand_gx),
    .gy        (cand_gy),
    .ax        (cand_ax),
    .ay        (cand_ay),
    .flags     (cand_flags),
    .out_valid (snap.valid),
    .out_ready (snap.ready),
    .snap_x    (snap.snap_x),
    .snap_y    (snap.snap_y),
    .found     (snap.found)
  );

endmodule

`default_nettype wire

[hw/rtl/ngps_checker.sv]
// Port-level checker of the grid point snap core and its bind.
// Depends on ngps_pkg and nearest_grid_point_snap_core_defines.svh.
`default_nettype none

`include "nearest_grid_point_snap_core_defines.svh"

module ngps_checker import ngps_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  point_ready,
  input logic                  snap_valid,
  input logic                  snap_ready,
  input logic [COORD_BITS-1:0] snap_x,
  input logic [COORD_BITS-1:0] snap_y,
  input logic                  snap_found
);

  logic                      empty_out;
  logic                      found_out;
  logic                      snap_zero;
  logic                      snap_off_axis;
  logic                      stall;
  logic [2*COORD_BITS:0]     snap_word;

  assign empty_out     = snap_valid && !snap_found;
  assign found_out     = snap_valid && snap_found;
  assign snap_zero     = (snap_x == '0) && (snap_y == '0);
  assign snap_off_axis = (snap_x != '0) && (snap_y != '0);
  assign stall         = snap_valid && !snap_ready;
  assign snap_word     = {snap_x, snap_y, snap_found};

  `NGPS_ASSERT_IMPLIES(a_empty_zero, clk, rst, empty_out, snap_zero, "empty result not zero")
  `NGPS_ASSERT_IMPLIES(a_found_nonzero, clk, rst, found_out, snap_off_axis, "grid point on axis")
  `NGPS_ASSERT_IMPLIES(a_idle_ready, clk, rst, !snap_valid, point_ready, "idle core refuses input")
  `NGPS_ASSERT_NEXT(a_stall_hold, clk, rst, stall, snap_valid && $stable(snap_word), "result not held")

endmodule

bind nearest_grid_point_snap_core ngps_checker #(.COORD_BITS(COORD_BITS)) u_ngps_checker (
  .clk         (clk),
  .rst         (rst),
  .point_ready (point.ready),
  .snap_valid  (snap.valid),
  .snap_ready  (snap.ready),
  .snap_x      (snap.snap_x),
  .snap_y      (snap.snap_y),
  .snap_found  (snap.found)
);

`default_nettype wire
